FILE: rtl/msfc_pkg.sv
package msfc_pkg;

    localparam int LONG_BYTES   = 14;
    localparam int SHORT_BYTES  = 7;
    localparam int DECODE_BYTES = 11;
    localparam int COUNT_W      = 4;
    localparam int DATA_W       = 144;

    localparam logic [23:0] CRC_GEN   = 24'hFFF409;
    localparam logic [3:0]  COUNT_MAX = 4'd15;
    localparam logic [3:0]  SNAP_COUNT = 4'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_CRC = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    localparam logic [4:0] DF_ALL_CALL = 5'd11;
    localparam logic [4:0] DF_EXT      = 5'd17;
    localparam logic [4:0] DF_NON_TRANSP = 5'd18;

    localparam logic [4:0] TC_IDENT_LO = 5'd1;
    localparam logic [4:0] TC_IDENT_HI = 5'd4;
    localparam logic [4:0] TC_POS_LO   = 5'd9;
    localparam logic [4:0] TC_POS_HI   = 5'd18;
    localparam logic [4:0] TC_POS2_LO  = 5'd20;
    localparam logic [4:0] TC_POS2_HI  = 5'd22;

    localparam logic [16:0] ALT_STEP   = 17'd25;
    localparam logic [16:0] ALT_OFFSET = 17'd1000;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         downlink_format;
        logic [4:0]         msg_type;
        logic [23:0]        aircraft_address;
        logic [2:0]         sub_field;
        logic [47:0]        callsign_codes;
        logic signed [16:0] baro_alt;
        logic               altitude_valid;
        logic               cpr_odd;
        logic [16:0]        cpr_latitude;
        logic [16:0]        cpr_longitude;
    } result_t;

    // eight shift steps of the crc-24 divider, bits enter msb first
    function automatic logic [23:0] crc_byte(input logic [23:0] rem, input logic [7:0] b);
        logic [23:0] r;
        logic        top;
        r = rem;
        for (int i = 7; i >= 0; i--)
        begin
            top = r[23];
            r = {r[22:0], b[i]};
            if (top)
            begin
                r = r ^ CRC_GEN;
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/msfc_decode.sv
module msfc_decode import msfc_pkg::*; #(
    parameter int LONG_FRAME_BYTES = LONG_BYTES
) (
    input  logic [DECODE_BYTES-1:0][7:0] frame,
    input  logic [COUNT_W-1:0]           len,
    input  logic                         crc_zero,
    input  logic [23:0]                  crc_snap,
    output result_t                      res
);

    logic        is_short;
    logic        is_long;
    logic [4:0]  df;
    logic [4:0]  tc;
    logic        ext_df;
    logic        addr_df;
    logic [11:0] alt_code;
    logic [10:0] alt_n;
    logic [16:0] alt_scaled;
    logic        pos_tc;
    logic        ident_tc;

    always_comb
    begin
        is_short   = (len == COUNT_W'(SHORT_BYTES));
        is_long    = (len == COUNT_W'(LONG_FRAME_BYTES));
        df         = frame[0][7:3];
        tc         = frame[4][7:3];
        ext_df     = (df == DF_EXT) || (df == DF_NON_TRANSP);
        addr_df    = ext_df || (df == DF_ALL_CALL);
        ident_tc   = (tc >= TC_IDENT_LO) && (tc <= TC_IDENT_HI);
        pos_tc     = ((tc >= TC_POS_LO) && (tc <= TC_POS_HI)) ||
                     ((tc >= TC_POS2_LO) && (tc <= TC_POS2_HI));
        alt_code   = {frame[5], frame[6][7:4]};
        // drop the q bit to get the 11-bit count of 25 ft steps
        alt_n      = {alt_code[11:5], alt_code[3:0]};
        alt_scaled = 17'(alt_n) * ALT_STEP - ALT_OFFSET;

        res = '0;
        res.downlink_format = df;
        if (!is_short && !is_long)
        begin
            res.status = ST_LEN;
        end
        else
        begin
            res.status = crc_zero ? ST_OK : ST_CRC;
            if (addr_df)
            begin
                res.aircraft_address = {frame[1], frame[2], frame[3]};
            end
            else if (is_short)
            begin
                // parity field carries address xor crc of the first four bytes
                res.aircraft_address = crc_snap ^ {frame[4], frame[5], frame[6]};
            end
            if (is_long && ext_df)
            begin
                res.msg_type  = tc;
                res.sub_field = frame[4][2:0];
                if (ident_tc)
                begin
                    res.callsign_codes = {frame[5], frame[6], frame[7],
                                          frame[8], frame[9], frame[10]};
                end
                if (pos_tc)
                begin
                    if (alt_code[4])
                    begin
                        res.baro_alt       = alt_scaled;
                        res.altitude_valid = 1'b1;
                    end
                    res.cpr_odd       = frame[6][2];
                    res.cpr_latitude  = {frame[6][1:0], frame[7], frame[8][7:1]};
                    res.cpr_longitude = {frame[8][0], frame[9], frame[10]};
                end
            end
        end
    end

endmodule

FILE: rtl/mode_s_frame_check_and_fields.sv
// Mode S reply checker and field extractor.
// Slave side: one reply byte per transaction on s_tdata, in air order,
// with s_tlast set on the final byte of the reply.
// Master side: one transaction per reply, issued for the byte marked last.
// m_tuser holds the status (ok, crc mismatch, bad length); m_tdata holds
// the decoded fields packed from bit 0 up.
// Each accepted byte is held in an input register; when it advances from
// there it runs the eight-bit crc-24 update, the byte store write and, for
// a last byte, the whole field decode into the result register.
// A last byte passes the input register and then the result register to m_tvalid.
// Throughput: one byte per cycle while s_tready is high, set by the crc update.
// A stalled result holds in the result register; bytes keep flowing until
// a second last byte arrives while the result is still waiting, and then
// s_tready drops until m_tready takes the result.
// Reset clears the crc remainder, snapshot, byte count and both valid
// flags; the byte store is not cleared, since decoding only reads bytes of
// the current reply.
module mode_s_frame_check_and_fields import msfc_pkg::*; #(
    parameter int LONG_FRAME_BYTES = LONG_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte
    input  logic              s_tlast,   // last_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    // downlink_format, msg_type, aircraft_address, sub_field, callsign_codes,
    // baro_alt, altitude_valid, cpr_odd, cpr_latitude, cpr_longitude, zero pad
    output logic [DATA_W-1:0] m_tdata,
    output logic [1:0]        m_tuser    // status
);

    localparam int IDX_W = $clog2(LONG_FRAME_BYTES);

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          in_last_reg;
    logic [23:0]                   crc_reg;
    logic [23:0]                   crc_next;
    logic [23:0]                   snap_reg;
    logic [COUNT_W-1:0]            count_reg;
    logic [COUNT_W-1:0]            count_next;
    logic [7:0]                    store_reg [LONG_FRAME_BYTES];
    logic [DECODE_BYTES-1:0][7:0]  view;
    logic                          advance;
    logic                          out_valid_reg;
    logic [DATA_W-1:0]             out_data_reg;
    logic [1:0]                    out_status_reg;
    result_t                       res;
    logic [DATA_W-1:0]             res_packed;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        crc_next   = crc_byte(crc_reg, in_byte_reg);
        count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + COUNT_W'(1);
        // current byte is not in the store yet
        for (int i = 0; i < DECODE_BYTES; i++)
        begin
            view[i] = (count_reg == COUNT_W'(i)) ? in_byte_reg : store_reg[i];
        end
    end

    msfc_decode #(
        .LONG_FRAME_BYTES(LONG_FRAME_BYTES)
    ) u_decode (
        .frame    (view),
        .len      (count_next),
        .crc_zero (crc_next == 24'd0),
        .crc_snap (snap_reg),
        .res      (res)
    );

    assign res_packed = {6'd0, res.cpr_longitude, res.cpr_latitude, res.cpr_odd,
                         res.altitude_valid, res.baro_alt, res.callsign_codes,
                         res.sub_field, res.aircraft_address, res.msg_type,
                         res.downlink_format};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= '0;
            snap_reg  <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            if (count_next == SNAP_COUNT)
            begin
                snap_reg <= crc_next;
            end
            if (in_last_reg)
            begin
                crc_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (count_reg < COUNT_W'(LONG_FRAME_BYTES)))
        begin
            store_reg[count_reg[IDX_W-1:0]] <= in_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg   <= res_packed;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    a_frame_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (count_reg == '0 && crc_reg == '0))
        else $error("crc or byte count not cleared after frame close");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_CRC || m_tuser == ST_LEN))
        else $error("illegal status code");

    a_bad_len_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_LEN) |-> (m_tdata[DATA_W-1:5] == '0))
        else $error("bad length result carries decoded fields");

    a_alt_needs_pos_tc: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[102]) |-> (m_tdata[9:5] >= TC_POS_LO && m_tdata[9:5] <= TC_POS2_HI))
        else $error("altitude valid outside position type codes");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && in_last_reg && out_valid_reg))
        else $error("input stalled without a waiting result");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import msfc_pkg::*;

    localparam logic [23:0] CRC_POLY    = 24'hFFF409;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          RANDOM_BYTES = 1200;

    typedef struct packed {
        logic [5:0]         pad;
        logic [16:0]        cpr_longitude;
        logic [16:0]        cpr_latitude;
        logic               cpr_odd;
        logic               altitude_valid;
        logic signed [16:0] baro_alt;
        logic [47:0]        callsign_codes;
        logic [2:0]         sub_field;
        logic [23:0]        aircraft_address;
        logic [4:0]         msg_type;
        logic [4:0]         downlink_format;
    } reply_fields_t;

    typedef struct packed {
        logic [1:0]    status;
        reply_fields_t f;
    } expected_reply_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'h00;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;

    // frame checker state mirrored from the byte stream
    logic [23:0] crc_rem_q = '0;
    logic [23:0] crc_snap_q = '0;
    logic [3:0]  byte_cnt_q = '0;
    logic [7:0]  frame_q [0:LONG_BYTES-1];

    expected_reply_t pending_replies[$];
    logic [7:0]      frame_buf[$];

    int error_count = 0;
    int reply_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    mode_s_frame_check_and_fields uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // bits enter at the bottom, msb of the byte first
    function automatic logic [23:0] crc_shift_byte(input logic [23:0] r, input logic [7:0] b);
        for (int k = 7; k >= 0; k--)
        begin
            if (r[23])
                r = {r[22:0], b[k]} ^ CRC_POLY;
            else
                r = {r[22:0], b[k]};
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 60)
            $display("[%0t] reply %0d: %s", $time, reply_count, what);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // runs one accepted byte through the mirrored state, queues the reply on the last byte
    task automatic track_byte(input logic [7:0] b, input logic is_last);
        expected_reply_t e;
        logic [4:0]      df;
        logic [4:0]      tc;
        logic [3:0]      len;
        logic [11:0]     alt_code;
        logic [10:0]     alt_n;
        int              alt_i;
        if (byte_cnt_q < LONG_BYTES)
            frame_q[byte_cnt_q] = b;
        crc_rem_q = crc_shift_byte(crc_rem_q, b);
        if (byte_cnt_q != 4'd15)
            byte_cnt_q++;
        if (byte_cnt_q == 4'd4)
            crc_snap_q = crc_rem_q;
        if (is_last)
        begin
            e = '0;
            len = byte_cnt_q;
            df = frame_q[0][7:3];
            e.f.downlink_format = df;
            if (len != SHORT_BYTES && len != LONG_BYTES)
            begin
                e.status = ST_LEN;
            end
            else
            begin
                e.status = (crc_rem_q != 24'd0) ? ST_CRC : ST_OK;
                if (df == DF_ALL_CALL || df == DF_EXT || df == DF_NON_TRANSP)
                    e.f.aircraft_address = {frame_q[1], frame_q[2], frame_q[3]};
                else if (len == SHORT_BYTES)
                    e.f.aircraft_address = crc_snap_q ^ {frame_q[4], frame_q[5], frame_q[6]};
                if (len == LONG_BYTES && (df == DF_EXT || df == DF_NON_TRANSP))
                begin
                    tc = frame_q[4][7:3];
                    e.f.msg_type = tc;
                    e.f.sub_field = frame_q[4][2:0];
                    if (tc >= TC_IDENT_LO && tc <= TC_IDENT_HI)
                        e.f.callsign_codes = {frame_q[5], frame_q[6], frame_q[7],
                                              frame_q[8], frame_q[9], frame_q[10]};
                    if ((tc >= TC_POS_LO && tc <= TC_POS_HI) ||
                        (tc >= TC_POS2_LO && tc <= TC_POS2_HI))
                    begin
                        alt_code = {frame_q[5], frame_q[6][7:4]};
                        // q bit set means 25 ft steps with the q bit squeezed out
                        if (alt_code[4])
                        begin
                            alt_n = {alt_code[11:5], alt_code[3:0]};
                            alt_i = alt_n * 25 - 1000;
                            e.f.baro_alt = alt_i[16:0];
                            e.f.altitude_valid = 1'b1;
                        end
                        e.f.cpr_odd = frame_q[6][2];
                        e.f.cpr_latitude = {frame_q[6][1:0], frame_q[7], frame_q[8][7:1]};
                        e.f.cpr_longitude = {frame_q[8][0], frame_q[9], frame_q[10]};
                    end
                end
            end
            crc_rem_q = '0;
            byte_cnt_q = '0;
            pending_replies.push_back(e);
        end
    endtask

    always @(posedge clk)
    begin : check_replies
        reply_fields_t   got;
        expected_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = reply_fields_t'(m_tdata);
            if (pending_replies.size() == 0)
            begin
                report_mismatch("reply with nothing pending");
            end
            else
            begin
                want = pending_replies.pop_front();
                compare_field("status", m_tuser, want.status);
                compare_field("downlink_format", got.downlink_format, want.f.downlink_format);
                compare_field("msg_type", got.msg_type, want.f.msg_type);
                compare_field("aircraft_address", got.aircraft_address,
                              want.f.aircraft_address);
                compare_field("sub_field", got.sub_field, want.f.sub_field);
                compare_field("callsign_codes", got.callsign_codes, want.f.callsign_codes);
                compare_field("baro_alt", got.baro_alt, want.f.baro_alt);
                compare_field("altitude_valid", got.altitude_valid, want.f.altitude_valid);
                compare_field("cpr_odd", got.cpr_odd, want.f.cpr_odd);
                compare_field("cpr_latitude", got.cpr_latitude, want.f.cpr_latitude);
                compare_field("cpr_longitude", got.cpr_longitude, want.f.cpr_longitude);
                compare_field("pad", got.pad, want.f.pad);
            end
            reply_count++;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        track_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic rand_body(input logic [4:0] df, input int nbytes);
        frame_buf.delete();
        frame_buf.push_back({df, 3'($urandom_range(7))});
        for (int i = 1; i < nbytes; i++)
            frame_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic fill_bytes(input int first, input int last, input logic [7:0] v);
        for (int i = first; i <= last; i++)
            frame_buf[i] = v;
    endtask

    // parity is the body's remainder pushed through three zero bytes
    task automatic send_frame(input bit add_parity, input bit good_crc);
        logic [23:0] par;
        par = '0;
        if (add_parity)
        begin
            foreach (frame_buf[i])
                par = crc_shift_byte(par, frame_buf[i]);
            repeat (3)
                par = crc_shift_byte(par, 8'h00);
            if (!good_crc)
                par = par ^ (24'd1 << $urandom_range(23));
            frame_buf.push_back(par[23:16]);
            frame_buf.push_back(par[15:8]);
            frame_buf.push_back(par[7:0]);
        end
        // valid stays up so the next frame can follow back to back
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic ext_frame(input logic [4:0] df, input logic [4:0] tc, input logic [2:0] sub);
        rand_body(df, 11);
        frame_buf[4] = {tc, sub};
    endtask

    task automatic test_directed_frames();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        // identification, callsign codes all ones then all zeros
        ext_frame(DF_EXT, TC_IDENT_HI, 3'd7);
        fill_bytes(5, 10, 8'hFF);
        send_frame(1, 1);
        ext_frame(DF_EXT, TC_IDENT_LO, 3'd0);
        fill_bytes(5, 10, 8'h00);
        send_frame(1, 1);
        // airborne position, highest q-bit altitude and all-ones cpr
        ext_frame(DF_NON_TRANSP, TC_POS_LO, 3'd7);
        fill_bytes(5, 10, 8'hFF);
        send_frame(1, 1);
        // lowest q-bit altitude, zero cpr
        ext_frame(DF_EXT, TC_POS2_LO, 3'd0);
        frame_buf[5] = 8'h01;
        fill_bytes(6, 10, 8'h00);
        send_frame(1, 1);
        // gillham coded altitude, q bit clear
        ext_frame(DF_EXT, TC_POS_HI, 3'd3);
        frame_buf[5] = 8'hAA;
        send_frame(1, 1);
        // altitude code zero
        ext_frame(DF_NON_TRANSP, TC_POS2_HI, 3'd1);
        frame_buf[5] = 8'h00;
        frame_buf[6] = 8'h0F;
        send_frame(1, 1);
        // type codes with no decoded payload
        ext_frame(DF_EXT, 5'd19, 3'd1);
        send_frame(1, 1);
        ext_frame(DF_EXT, 5'd0, 3'd0);
        send_frame(1, 1);
        ext_frame(DF_NON_TRANSP, 5'd31, 3'd5);
        send_frame(1, 1);
        // short frames: direct address, address from parity, all zero
        rand_body(DF_ALL_CALL, 4);
        send_frame(1, 1);
        rand_body(5'd4, 4);
        send_frame(1, 0);
        frame_buf.delete();
        repeat (7)
            frame_buf.push_back(8'h00);
        send_frame(0, 0);
        // long frame outside the squitter formats
        rand_body(5'd20, 11);
        send_frame(1, 1);
        // crc mismatch still decodes
        ext_frame(DF_EXT, 5'd11, 3'd0);
        send_frame(1, 0);
        // bad lengths, one byte of all ones and an overlong run past the counter limit
        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame(0, 0);
        rand_body(DF_EXT, 8);
        send_frame(0, 0);
        rand_body(DF_EXT, 13);
        send_frame(0, 0);
        rand_body(DF_ALL_CALL, 15);
        send_frame(0, 0);
        rand_body(DF_EXT, 20);
        send_frame(0, 0);
        // counter must be clear again after the overlong frame
        rand_body(DF_ALL_CALL, 4);
        send_frame(1, 1);
        wait_for_replies();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int nbytes);
        int         stop_at;
        int         sel;
        int         len;
        logic [4:0] tc;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
            begin
                case ($urandom_range(3))
                    0, 1:
                        tc = $urandom_range(1) ? 5'($urandom_range(TC_POS_LO, TC_POS_HI))
                                               : 5'($urandom_range(TC_POS2_LO, TC_POS2_HI));
                    2: tc = 5'($urandom_range(TC_IDENT_LO, TC_IDENT_HI));
                    default: tc = 5'($urandom_range(31));
                endcase
                ext_frame($urandom_range(1) ? DF_EXT : DF_NON_TRANSP, tc,
                          3'($urandom_range(7)));
                send_frame(1, $urandom_range(9) != 0);
            end
            else if (sel < 65)
            begin
                rand_body($urandom_range(1) ? DF_ALL_CALL : 5'($urandom_range(31)), 4);
                send_frame(1, $urandom_range(4) != 0);
            end
            else if (sel < 75)
            begin
                rand_body(5'($urandom_range(31)), 11);
                send_frame(1, $urandom_range(1) != 0);
            end
            else
            begin
                // noise: random bytes, lengths biased toward the legal ones
                if ($urandom_range(3) == 0)
                    len = $urandom_range(1) ? SHORT_BYTES : LONG_BYTES;
                else
                    len = $urandom_range(1, 20);
                rand_body(5'($urandom_range(31)), len);
                send_frame(0, 0);
            end
        end
        wait_for_replies();
    endtask

    // results held back for a long stretch while short frames keep coming
    task automatic test_output_holdoff();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 300;
        repeat (6)
        begin
            rand_body(DF_ALL_CALL, 4);
            send_frame(1, 1);
        end
        wait_for_replies();
    endtask

    initial
    begin
        for (int i = 0; i < LONG_BYTES; i++)
            frame_q[i] = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_random_traffic(0, 0, RANDOM_BYTES / 4);
        test_random_traffic(55, 0, RANDOM_BYTES / 4);
        test_random_traffic(0, 55, RANDOM_BYTES / 4);
        test_random_traffic(19, 19, RANDOM_BYTES / 4);
        test_output_holdoff();
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/msfc_pkg.sv
rtl/msfc_decode.sv
rtl/mode_s_frame_check_and_fields.sv
dv/tb_top.sv
